/* rtl/ctf_pkg.sv */
`timescale 1ns / 1ps
package ctf_pkg;

   // CORDIC configuration.
   localparam int CordicIterations = 16;
   localparam int AngleFracBits    = 16;
   localparam int TabLen           = 24;
   localparam int TabFrac          = 24;
   localparam int IterW            = $clog2(CordicIterations);
   localparam int ZW               = AngleFracBits + 9;
   localparam int CordW            = 34;
   localparam int NumShift         = 14;
   localparam int AccLimit         = 5898240;

   // Square root unit: 60-bit radicand, one root bit per cycle.
   localparam int SqrtSteps = 30;
   localparam int SqrtStepW = 5;

   // Gyro increment: (|g| * dt * 256 + 500) / 1000, one quotient bit per cycle.
   localparam int DivW    = 59;
   localparam int DivStepW = 6;
   localparam int DivRemW = 10;
   localparam logic [DivRemW:0] GyroDivisor = 11'd1000;
   localparam logic [DivW-1:0]  GyroRound   = 59'd500;
   localparam int IncrW   = 51;

   // Blend unit.
   localparam int WeightW    = 16;
   localparam int WeightStepW = 4;
   localparam int InnerW     = 52;
   localparam int InnerRegW  = 49;
   localparam int BlendSumW  = 67;
   localparam logic [WeightW-1:0] BlendWeightReset = 16'd62915;

   // atan(2^-i) in degrees, Q24.
   localparam logic [31:0] AtanTab [TabLen] = '{
      32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
      32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
      32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
      32'd234684,    32'd117342,    32'd58671,     32'd29335,
      32'd14668,     32'd7334,      32'd3667,      32'd1833,
      32'd917,       32'd458,       32'd229,       32'd115
   };

   function automatic logic [ZW-1:0] atan_step(input logic [IterW-1:0] idx);
      logic [31:0] v;
      v = AtanTab[idx] + (32'd1 << (TabFrac - 1 - AngleFracBits));
      return ZW'(v >> (TabFrac - AngleFracBits));
   endfunction

   typedef struct packed {
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic signed [19:0] gyro_x;
      logic signed [19:0] gyro_y;
      logic signed [19:0] gyro_z;
      logic [31:0]        tick_ms;
   } ctf_req_type;

   typedef struct packed {
      logic signed [31:0] roll_angle;
      logic signed [31:0] pitch_angle;
      logic signed [31:0] yaw_angle;
      logic signed [23:0] accel_roll;
      logic signed [23:0] accel_pitch;
   } ctf_rsp_type;

endpackage

/* rtl/imu_complementary_tilt_filter_core.sv */
`timescale 1ns / 1ps
// Each result is set by two serial square roots, two 16-step CORDIC runs and a
// 16-step blend.
// The core takes one sample at a time; a finished result waits in the output register
// while the next sample is taken in.
// Reset clears the estimates and the last timestamp and sets the weight to 62915.
module imu_complementary_tilt_filter_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ctf_pkg::ctf_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ctf_pkg::ctf_rsp_type rsp_data,
   input  logic                 csr_wr_en,
   input  logic [15:0]          csr_wr_data
);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_PREP  = 7'b0000010,
      S_ROLL  = 7'b0000100,
      S_PITCH = 7'b0001000,
      S_GYRO  = 7'b0010000,
      S_BLEND = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type                 state_ff, state_in;
   ctf_pkg::ctf_req_type      item_ff, item_in;
   ctf_pkg::ctf_rsp_type      rsp_ff, rsp_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [31:0]               dt_ff, dt_in, last_tick_ff, last_tick_in;
   logic [15:0]               weight_ff, weight_in;
   logic [31:0]               ax2, ay2, az2;
   logic signed [31:0]        axe, aye, aze;
   logic signed [23:0]        acc_roll_ff, acc_roll_in, acc_pitch_ff, acc_pitch_in;
   logic signed [31:0]        roll_est_ff, roll_est_in, pitch_est_ff, pitch_est_in;
   logic signed [31:0]        yaw_est_ff, yaw_est_in, yaw_new_ff, yaw_new_in;
   logic signed [ctf_pkg::InnerW-1:0] yaw_sum;

   logic [31:0]               sq_sel;
   logic signed [16:0]        num_sel;
   logic                      sqrt_start, sqrt_done, cord_done, gyro_start, blend_start;
   logic [ctf_pkg::SqrtSteps-1:0] root;
   logic signed [23:0]        angle;
   logic                      busy_x, busy_y, busy_z;
   logic signed [ctf_pkg::IncrW-1:0] incr_x, incr_y, incr_z;
   logic                      roll_done, pitch_done, load;
   logic signed [31:0]        roll_res, pitch_res;

   assign sqrt_start  = (state_ff == S_PREP) || ((state_ff == S_ROLL) && cord_done);
   assign sq_sel      = (state_ff == S_PREP) ? (ay2 + az2) : (ax2 + az2);
   assign num_sel     = (state_ff == S_ROLL) ? -17'(item_ff.accel_x) : 17'(item_ff.accel_y);
   assign gyro_start  = (state_ff == S_PREP);
   assign blend_start = (state_ff == S_GYRO) && !busy_x && !busy_y && !busy_z;
   assign load        = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   ctf_isqrt u_isqrt (
      .clock(clock), .reset(reset), .start(sqrt_start), .sq(sq_sel),
      .done(sqrt_done), .root(root)
   );

   ctf_cordic u_cordic (
      .clock(clock), .reset(reset), .start(sqrt_done), .x_start(root), .num(num_sel),
      .done(cord_done), .angle(angle)
   );

   ctf_gyro_incr u_incr_x (
      .clock(clock), .reset(reset), .start(gyro_start), .gyro(item_ff.gyro_x),
      .dt(dt_ff), .busy(busy_x), .incr(incr_x)
   );

   ctf_gyro_incr u_incr_y (
      .clock(clock), .reset(reset), .start(gyro_start), .gyro(item_ff.gyro_y),
      .dt(dt_ff), .busy(busy_y), .incr(incr_y)
   );

   ctf_gyro_incr u_incr_z (
      .clock(clock), .reset(reset), .start(gyro_start), .gyro(item_ff.gyro_z),
      .dt(dt_ff), .busy(busy_z), .incr(incr_z)
   );

   // Roll integrates the y rate and pitch the x rate.
   ctf_blend u_blend_roll (
      .clock(clock), .reset(reset), .start(blend_start), .weight(weight_ff),
      .est(roll_est_ff), .incr(incr_y), .acc(acc_roll_ff),
      .done(roll_done), .result(roll_res)
   );

   ctf_blend u_blend_pitch (
      .clock(clock), .reset(reset), .start(blend_start), .weight(weight_ff),
      .est(pitch_est_ff), .incr(incr_x), .acc(acc_pitch_ff),
      .done(pitch_done), .result(pitch_res)
   );

   always_comb begin
      axe = 32'(item_ff.accel_x);
      aye = 32'(item_ff.accel_y);
      aze = 32'(item_ff.accel_z);
      ax2 = 32'(axe * axe);
      ay2 = 32'(aye * aye);
      az2 = 32'(aze * aze);
      yaw_sum = ctf_pkg::InnerW'(yaw_est_ff) + ctf_pkg::InnerW'(incr_z);
      if (yaw_sum > ctf_pkg::InnerW'(64'sd2147483647)) begin
         yaw_new_in = 32'sh7fffffff;
      end else if (yaw_sum < -ctf_pkg::InnerW'(64'sd2147483648)) begin
         yaw_new_in = 32'sh80000000;
      end else begin
         yaw_new_in = yaw_sum[31:0];
      end

      state_in = state_ff;
      item_in = item_ff;
      dt_in = dt_ff;
      last_tick_in = last_tick_ff;
      acc_roll_in = acc_roll_ff;
      acc_pitch_in = acc_pitch_ff;
      roll_est_in = roll_est_ff;
      pitch_est_in = pitch_est_ff;
      yaw_est_in = yaw_est_ff;
      rsp_in = rsp_ff;
      weight_in = csr_wr_en ? csr_wr_data : weight_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in      = req_data;
               dt_in        = req_data.tick_ms - last_tick_ff;
               last_tick_in = req_data.tick_ms;
               state_in     = S_PREP;
            end
         end
         S_PREP: begin
            state_in = S_ROLL;
         end
         S_ROLL: begin
            if (cord_done) begin
               acc_roll_in = angle;
               state_in    = S_PITCH;
            end
         end
         S_PITCH: begin
            if (cord_done) begin
               acc_pitch_in = angle;
               state_in     = S_GYRO;
            end
         end
         S_GYRO: begin
            if (blend_start) begin
               state_in = S_BLEND;
            end
         end
         S_BLEND: begin
            if (roll_done && pitch_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (load) begin
               rsp_in.roll_angle  = roll_res;
               rsp_in.pitch_angle = pitch_res;
               rsp_in.yaw_angle   = yaw_new_ff;
               rsp_in.accel_roll  = acc_roll_ff;
               rsp_in.accel_pitch = acc_pitch_ff;
               roll_est_in  = roll_res;
               pitch_est_in = pitch_res;
               yaw_est_in   = yaw_new_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         weight_ff    <= ctf_pkg::BlendWeightReset;
         last_tick_ff <= '0;
         roll_est_ff  <= '0;
         pitch_est_ff <= '0;
         yaw_est_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         weight_ff    <= weight_in;
         last_tick_ff <= last_tick_in;
         roll_est_ff  <= roll_est_in;
         pitch_est_ff <= pitch_est_in;
         yaw_est_ff   <= yaw_est_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      dt_ff        <= dt_in;
      acc_roll_ff  <= acc_roll_in;
      acc_pitch_ff <= acc_pitch_in;
      yaw_new_ff   <= yaw_new_in;
      rsp_ff       <= rsp_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* rtl/ctf_isqrt.sv */
`timescale 1ns / 1ps
module ctf_isqrt (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [31:0]                     sq,
   output logic                            done,
   output logic [ctf_pkg::SqrtSteps-1:0]   root
);

   logic [59:0]                          op_ff, op_in;
   logic [33:0]                          rem_ff, rem_in;
   logic [ctf_pkg::SqrtSteps-1:0]        root_ff, root_in;
   logic [ctf_pkg::SqrtStepW-1:0]        cnt_ff, cnt_in;
   logic                                 busy_ff, busy_in;
   logic                                 done_ff, done_in;
   logic [33:0]                          cand;
   logic [33:0]                          trial;
   logic                                 fits;

   // Classic digit-by-digit root: two radicand bits enter per cycle.
   always_comb begin
      cand  = {rem_ff[31:0], op_ff[59:58]};
      trial = {2'b00, root_ff, 2'b01};
      fits  = (cand >= trial);
      op_in = op_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         op_in   = {sq, 28'd0};
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         op_in   = {op_ff[57:0], 2'b00};
         rem_in  = fits ? (cand - trial) : cand;
         root_in = {root_ff[ctf_pkg::SqrtSteps-2:0], fits};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == ctf_pkg::SqrtStepW'(ctf_pkg::SqrtSteps - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

/* rtl/ctf_cordic.sv */
`timescale 1ns / 1ps
module ctf_cordic (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [ctf_pkg::SqrtSteps-1:0]  x_start,
   input  logic signed [16:0]             num,
   output logic                           done,
   output logic signed [23:0]             angle
);

   localparam int ConvW  = ctf_pkg::ZW + 8;
   localparam int ShR    = (ctf_pkg::AngleFracBits > 16) ? ctf_pkg::AngleFracBits - 16 : 0;
   localparam int ShL    = (ctf_pkg::AngleFracBits < 16) ? 16 - ctf_pkg::AngleFracBits : 0;
   localparam int RndBit = (ShR > 0) ? ShR - 1 : 0;
   localparam logic signed [ConvW-1:0] AccHi = ConvW'(ctf_pkg::AccLimit);
   localparam logic signed [ConvW-1:0] AccLo = -AccHi;

   logic signed [ctf_pkg::CordW-1:0] x_ff, x_in, y_ff, y_in, dx, dy;
   logic signed [ctf_pkg::ZW-1:0]    z_ff, z_in, t;
   logic [ctf_pkg::IterW-1:0]        i_ff, i_in;
   logic                             busy_ff, busy_in, done_ff, done_in;
   logic signed [23:0]               angle_ff, angle_in;
   logic signed [ConvW-1:0]          zc;

   always_comb begin
      dx = x_ff >>> i_ff;
      dy = y_ff >>> i_ff;
      t  = $signed(ctf_pkg::atan_step(i_ff));
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      i_in = i_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      angle_in = angle_ff;
      zc = '0;
      if (start) begin
         x_in = ctf_pkg::CordW'(x_start);
         y_in = ctf_pkg::CordW'(num) <<< ctf_pkg::NumShift;
         z_in = '0;
         i_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // A residual of exactly zero leaves the vector alone.
         if (y_ff > 0) begin
            x_in = x_ff + dy;
            y_in = y_ff - dx;
            z_in = z_ff + t;
         end else if (y_ff < 0) begin
            x_in = x_ff - dy;
            y_in = y_ff + dx;
            z_in = z_ff - t;
         end
         i_in = i_ff + 1'b1;
         if (i_ff == ctf_pkg::IterW'(ctf_pkg::CordicIterations - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            zc = ConvW'(z_in);
            if (ShR > 0) begin
               zc = (zc + $signed(ConvW'(1) << RndBit)) >>> ShR;
            end else begin
               zc = zc <<< ShL;
            end
            if (zc > AccHi) begin
               zc = AccHi;
            end else if (zc < AccLo) begin
               zc = AccLo;
            end
            angle_in = zc[23:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      i_ff <= i_in;
      angle_ff <= angle_in;
   end

   assign done  = done_ff;
   assign angle = angle_ff;

endmodule

/* rtl/ctf_gyro_incr.sv */
`timescale 1ns / 1ps
module ctf_gyro_incr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [19:0]                gyro,
   input  logic [31:0]                       dt,
   output logic                              busy,
   output logic signed [ctf_pkg::IncrW-1:0]  incr
);

   logic [19:0]                      mag;
   logic [50:0]                      prod;
   logic [ctf_pkg::DivW-1:0]         work_ff, work_in;
   logic [ctf_pkg::DivRemW-1:0]      rem_ff, rem_in;
   logic [ctf_pkg::DivRemW:0]        cand;
   logic                             ge;
   logic [ctf_pkg::DivStepW-1:0]     cnt_ff, cnt_in;
   logic                             neg_ff, neg_in;
   logic                             busy_ff, busy_in;
   logic [ctf_pkg::IncrW-1:0]        q;

   // Restoring division by the constant, one quotient bit per cycle. The
   // quotient bits shift in at the bottom of the dividend register.
   always_comb begin
      mag  = gyro[19] ? 20'(-gyro) : 20'(gyro);
      prod = 51'(mag) * 51'(dt);
      cand = {rem_ff, work_ff[ctf_pkg::DivW-1]};
      ge   = (cand >= ctf_pkg::GyroDivisor);
      work_in = work_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      if (start) begin
         work_in = {prod, 8'd0} + ctf_pkg::GyroRound;
         rem_in  = '0;
         cnt_in  = '0;
         neg_in  = gyro[19];
         busy_in = 1'b1;
      end else if (busy_ff) begin
         work_in = {work_ff[ctf_pkg::DivW-2:0], ge};
         rem_in  = ge ? ctf_pkg::DivRemW'(cand - ctf_pkg::GyroDivisor)
                      : ctf_pkg::DivRemW'(cand);
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == ctf_pkg::DivStepW'(ctf_pkg::DivW - 1)) begin
            busy_in = 1'b0;
         end
      end
      q = {1'b0, work_ff[ctf_pkg::IncrW-2:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
   end

   assign busy = busy_ff;
   assign incr = neg_ff ? -$signed(q) : $signed(q);

endmodule

/* rtl/ctf_blend.sv */
`timescale 1ns / 1ps
module ctf_blend (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [ctf_pkg::WeightW-1:0]       weight,
   input  logic signed [31:0]                est,
   input  logic signed [ctf_pkg::IncrW-1:0]  incr,
   input  logic signed [23:0]                acc,
   output logic                              done,
   output logic signed [31:0]                result
);

   localparam logic signed [ctf_pkg::InnerW-1:0] InnerHi = ctf_pkg::InnerW'(64'sd1 <<< 47);
   localparam logic signed [ctf_pkg::InnerW-1:0] InnerLo = -InnerHi;
   localparam logic signed [ctf_pkg::BlendSumW-1:0] OutHi =
      ctf_pkg::BlendSumW'(64'sd2147483647);
   localparam logic signed [ctf_pkg::BlendSumW-1:0] OutLo = -OutHi - 1;

   logic signed [ctf_pkg::InnerW-1:0]     inner;
   logic signed [ctf_pkg::InnerRegW-1:0]  inner_ff, inner_in;
   logic signed [23:0]                    acc_ff, acc_in;
   logic [ctf_pkg::WeightW-1:0]           weight_ff, weight_in;
   logic signed [ctf_pkg::BlendSumW-1:0]  diff_ff, diff_in, sum_ff, sum_in, shr;
   logic [ctf_pkg::WeightStepW-1:0]       cnt_ff, cnt_in;
   logic                                  prep_ff, prep_in, busy_ff, busy_in;
   logic                                  done_ff, done_in;
   logic signed [31:0]                    result_ff, result_in;

   // sum = weight * (inner - acc) + acc * 2^16 + 2^15, built by shift and add
   // over the weight bits, low bit first.
   always_comb begin
      inner = ctf_pkg::InnerW'(incr) + ctf_pkg::InnerW'(est);
      if (inner > InnerHi) begin
         inner = InnerHi;
      end else if (inner < InnerLo) begin
         inner = InnerLo;
      end
      inner_in = inner_ff;
      acc_in = acc_ff;
      weight_in = weight_ff;
      diff_in = diff_ff;
      sum_in = sum_ff;
      cnt_in = cnt_ff;
      prep_in = prep_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      result_in = result_ff;
      shr = '0;
      if (start) begin
         inner_in  = inner[ctf_pkg::InnerRegW-1:0];
         acc_in    = acc;
         weight_in = weight;
         prep_in   = 1'b1;
         busy_in   = 1'b1;
      end else if (prep_ff) begin
         diff_in = ctf_pkg::BlendSumW'(inner_ff) - ctf_pkg::BlendSumW'(acc_ff);
         sum_in  = (ctf_pkg::BlendSumW'(acc_ff) <<< 16) + ctf_pkg::BlendSumW'(32768);
         cnt_in  = '0;
         prep_in = 1'b0;
      end else if (busy_ff) begin
         if (weight_ff[0]) begin
            sum_in = sum_ff + diff_ff;
         end
         diff_in   = diff_ff <<< 1;
         weight_in = weight_ff >> 1;
         cnt_in    = cnt_ff + 1'b1;
         if (cnt_ff == ctf_pkg::WeightStepW'(ctf_pkg::WeightW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            shr = sum_in >>> 16;
            if (shr > OutHi) begin
               shr = OutHi;
            end else if (shr < OutLo) begin
               shr = OutLo;
            end
            result_in = shr[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_ff <= 1'b0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         prep_ff <= prep_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      inner_ff  <= inner_in;
      acc_ff    <= acc_in;
      weight_ff <= weight_in;
      diff_ff   <= diff_in;
      sum_ff    <= sum_in;
      cnt_ff    <= cnt_in;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

/* bench/imu_complementary_tilt_filter_core_tb.sv */
`timescale 1ns / 1ps
module imu_complementary_tilt_filter_core_tb;

   localparam int CycleLimit = 3000000;
   localparam int ItemsPerPhase = 180;
   localparam int NumPhases = 5;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   ctf_pkg::ctf_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   ctf_pkg::ctf_rsp_type rsp_data;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;

   imu_complementary_tilt_filter_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Filter state as the block should hold it.
   logic [15:0] alpha_q16;
   int          roll_est, pitch_est, yaw_est;
   logic [31:0] prev_tick;

   ctf_pkg::ctf_rsp_type attitude_q[$];
   int          errors = 0;
   int          samples_sent = 0;
   int          results_seen = 0;
   int          hold_requests = 0;
   bit          sender_no_gaps = 0;
   logic [31:0] gen_tick = '0;
   longint      cycle_count = 0;

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // Vectoring CORDIC: atan2(num, sqrt(sq)) in Q16 degrees.
   function automatic longint tilt_q16(longint num, longint unsigned sq);
      longint x, y, z, t, dx, dy;
      int sh;
      x = longint'(int_sqrt(sq << 28));
      y = num * 16384;
      z = 0;
      if (x == 0 && y == 0) return 0;
      for (int i = 0; i < ctf_pkg::CordicIterations && i < ctf_pkg::TabLen; i++) begin
         t = (longint'(ctf_pkg::AtanTab[i]) +
              (64'sd1 <<< (ctf_pkg::TabFrac - 1 - ctf_pkg::AngleFracBits)))
             >>> (ctf_pkg::TabFrac - ctf_pkg::AngleFracBits);
         dx = x >>> i;
         dy = y >>> i;
         if (y > 0) begin
            x = x + dy; y = y - dx; z = z + t;
         end else if (y < 0) begin
            x = x - dy; y = y + dx; z = z - t;
         end
      end
      sh = ctf_pkg::AngleFracBits - 16;
      if (sh > 0) z = (z + (64'sd1 <<< (sh - 1))) >>> sh;
      else if (sh < 0) z = z <<< (-sh);
      return clamp(z, -ctf_pkg::AccLimit, ctf_pkg::AccLimit);
   endfunction

   // Rate times elapsed ms, in Q16 degrees, rounded away from zero on ties.
   function automatic longint rate_increment(longint g, longint unsigned dt);
      longint unsigned mag, q;
      mag = g < 0 ? longint'(-g) : longint'(g);
      q = (mag * dt * 256 + 500) / 1000;
      return g < 0 ? -longint'(q) : longint'(q);
   endfunction

   function automatic int blend_angle(int est, longint incr, longint acc);
      longint inner, sum;
      inner = clamp(incr + longint'(est), -(64'sd1 <<< 47), 64'sd1 <<< 47);
      sum = longint'(alpha_q16) * inner + (65536 - longint'(alpha_q16)) * acc + 32768;
      return int'(clamp(sum >>> 16, -64'sd2147483648, 64'sd2147483647));
   endfunction

   function automatic ctf_pkg::ctf_rsp_type predict_attitude(ctf_pkg::ctf_req_type s);
      ctf_pkg::ctf_rsp_type r;
      longint ax, ay, az, acc_r, acc_p;
      longint unsigned dt;
      logic [31:0] dt32;
      ax = s.accel_x;
      ay = s.accel_y;
      az = s.accel_z;
      // The elapsed time wraps at 32 bits.
      dt32 = s.tick_ms - prev_tick;
      dt = dt32;
      acc_r = tilt_q16(-ax, ay * ay + az * az);
      acc_p = tilt_q16(ay, ax * ax + az * az);
      prev_tick = s.tick_ms;
      roll_est = blend_angle(roll_est, rate_increment(s.gyro_y, dt), acc_r);
      pitch_est = blend_angle(pitch_est, rate_increment(s.gyro_x, dt), acc_p);
      yaw_est = int'(clamp(longint'(yaw_est) + rate_increment(s.gyro_z, dt),
                           -64'sd2147483648, 64'sd2147483647));
      r.roll_angle = roll_est;
      r.pitch_angle = pitch_est;
      r.yaw_angle = yaw_est;
      r.accel_roll = acc_r[23:0];
      r.accel_pitch = acc_p[23:0];
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(150, 10);
   endfunction

   // Called at a rising edge; returns at the edge where the transfer happened, or after the random gap that follows it.
   task automatic send_sample(input ctf_pkg::ctf_req_type s, input bit typed,
                              input ctf_pkg::ctf_rsp_type typed_rsp);
      ctf_pkg::ctf_rsp_type p;
      int gap;
      req_valid <= 1'b1;
      req_data <= s;
      do @(posedge clock); while (!req_ready);
      p = predict_attitude(s);
      attitude_q.push_back(typed ? typed_rsp : p);
      samples_sent++;
      gap = sender_no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      while (attitude_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_weight(input logic [15:0] w);
      csr_wr_en <= 1'b1;
      csr_wr_data <= w;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      alpha_q16 = w;
   endtask

   function automatic logic signed [19:0] random_rate();
      int r;
      r = $urandom_range(99);
      if (r < 60) return 20'(int'($urandom_range(51200)) - 25600);
      if (r < 90) return 20'(int'($urandom_range(1024000)) - 512000);
      return 20'($urandom);
   endfunction

   function automatic ctf_pkg::ctf_req_type random_sample();
      ctf_pkg::ctf_req_type s;
      s.accel_x = 16'($urandom);
      s.accel_y = 16'($urandom);
      s.accel_z = 16'($urandom);
      if ($urandom_range(9) == 0) s.accel_x = '0;
      if ($urandom_range(9) == 0) s.accel_y = '0;
      if ($urandom_range(9) == 0) s.accel_z = '0;
      s.gyro_x = random_rate();
      s.gyro_y = random_rate();
      s.gyro_z = random_rate();
      // Mostly a steady sample clock, now and then a jump anywhere.
      if ($urandom_range(99) < 85) gen_tick = gen_tick + $urandom_range(20, 1);
      else gen_tick = $urandom;
      s.tick_ms = gen_tick;
      return s;
   endfunction

   task automatic check_field(input string name, input longint exp_v, input longint act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         errors++;
      end
   endtask

   // Result side: random stalls, plus a long hold-off when requested.
   initial begin
      int stall, holds_done;
      stall = 0;
      holds_done = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (attitude_q.size() == 0) begin
               $error("result arrived with no sample outstanding");
               errors++;
            end else begin
               ctf_pkg::ctf_rsp_type e;
               e = attitude_q.pop_front();
               check_field("roll_angle", e.roll_angle, rsp_data.roll_angle);
               check_field("pitch_angle", e.pitch_angle, rsp_data.pitch_angle);
               check_field("yaw_angle", e.yaw_angle, rsp_data.yaw_angle);
               check_field("accel_roll", e.accel_roll, rsp_data.accel_roll);
               check_field("accel_pitch", e.accel_pitch, rsp_data.accel_pitch);
            end
         end
         if (hold_requests != holds_done) begin
            holds_done = hold_requests;
            stall = 1500;
         end
         if (stall > 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else if ($urandom_range(99) < 20) begin
            stall = ($urandom_range(9) == 0) ? $urandom_range(200, 20) : $urandom_range(3, 1);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("imu_complementary_tilt_filter_core_tb: FAIL");
         $finish;
      end
   end

   typedef struct {
      ctf_pkg::ctf_req_type sample;
      bit                   typed;
      ctf_pkg::ctf_rsp_type expected;
   } stim_row_type;

   function automatic ctf_pkg::ctf_req_type mk(int ax, int ay, int az, int gx, int gy,
                                               int gz, logic [31:0] tick);
      ctf_pkg::ctf_req_type s;
      s.accel_x = 16'(ax); s.accel_y = 16'(ay); s.accel_z = 16'(az);
      s.gyro_x = 20'(gx); s.gyro_y = 20'(gy); s.gyro_z = 20'(gz);
      s.tick_ms = tick;
      return s;
   endfunction

   initial begin
      stim_row_type rows[$];
      logic [15:0] weights[NumPhases];
      alpha_q16 = ctf_pkg::BlendWeightReset;
      roll_est = 0; pitch_est = 0; yaw_est = 0; prev_tick = '0;

      // At reset with no acceleration and no elapsed time every output is zero, whatever the rates.
      rows.push_back('{mk(0, 0, 0, 0, 0, 0, 0), 1'b1, '0});
      rows.push_back('{mk(0, 0, 0, 512000, -512000, 524287, 0), 1'b1, '0});
      rows.push_back('{mk(-32768, 0, 0, 0, 0, 0, 0), 1'b0, '0});
      rows.push_back('{mk(32767, 0, 0, 0, 0, 0, 0), 1'b0, '0});
      rows.push_back('{mk(0, -32768, 0, 0, 0, 0, 0), 1'b0, '0});
      rows.push_back('{mk(0, 32767, 0, 0, 0, 0, 0), 1'b0, '0});
      rows.push_back('{mk(0, 0, 32767, 0, 0, 0, 5), 1'b0, '0});
      rows.push_back('{mk(0, 0, -32768, 0, 0, 0, 10), 1'b0, '0});
      rows.push_back('{mk(32767, 32767, 32767, 256, 256, 256, 15), 1'b0, '0});
      rows.push_back('{mk(-32768, -32768, -32768, -256, -256, -256, 20), 1'b0, '0});
      rows.push_back('{mk(1, -1, 0, 0, 0, 0, 25), 1'b0, '0});
      rows.push_back('{mk(1000, 1000, 16384, 12800, -12800, 6400, 1000), 1'b0, '0});
      // Timestamp going backwards wraps to a huge elapsed time.
      rows.push_back('{mk(0, 0, 16384, 512000, 512000, 512000, 5), 1'b0, '0});
      rows.push_back('{mk(0, 0, 16384, -512000, -512000, -512000, 4), 1'b0, '0});
      rows.push_back('{mk(0, 0, 16384, -524288, -524288, -524288, 32'hFFFF_FFFF), 1'b0, '0});
      rows.push_back('{mk(0, 0, 16384, 524287, 524287, 524287, 32'hFFFF_FFFE), 1'b0, '0});
      rows.push_back('{mk(-32768, 32767, 0, -1, 1, -1, 32'h8000_0000), 1'b0, '0});
      rows.push_back('{mk(0, 0, 0, 100, -100, 100, 32'h8000_0001), 1'b0, '0});
      rows.push_back('{mk(5, 0, 0, 0, 0, 0, 32'h8000_0002), 1'b0, '0});

      weights = '{16'd0, 16'd65535, 16'd32768, 16'($urandom), ctf_pkg::BlendWeightReset};

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) send_sample(rows[i].sample, rows[i].typed, rows[i].expected);
      req_valid <= 1'b0;
      gen_tick = prev_tick;

      for (int ph = 0; ph < NumPhases; ph++) begin
         drain_results();
         write_weight(weights[ph]);
         // First phase: back-to-back samples for the first 40, against a long result hold-off.
         sender_no_gaps = (ph == 0);
         if (ph == 0) hold_requests++;
         for (int n = 0; n < ItemsPerPhase; n++) begin
            if (ph == 0 && n == 40) sender_no_gaps = 0;
            send_sample(random_sample(), 1'b0, '0);
         end
         req_valid <= 1'b0;
      end

      drain_results();
      repeat (300) @(posedge clock);
      $display("Sent %0d samples, checked %0d results over %0d blend weights.",
               samples_sent, results_seen, NumPhases + 1);
      $display("Covered tilt extremes, zero denominators, wrapped timestamps and saturation.");
      if (errors == 0 && attitude_q.size() == 0) begin
         $display("imu_complementary_tilt_filter_core_tb: PASS");
      end else begin
         if (attitude_q.size() != 0) $error("%0d results never arrived", attitude_q.size());
         $display("imu_complementary_tilt_filter_core_tb: FAIL");
      end
      $finish;
   end

endmodule
